@@ hdl/sha256_digest_macros.svh @@
// assertion macros shared by the sha256 digest rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef SHA256_DIGEST_MACROS_SVH
`define SHA256_DIGEST_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define SHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hdl/sha256_pkg.sv @@
// types, constants and mixing functions of the sha256 digest block
// no dependencies
package sha256_pkg;

    typedef logic [0:7][31:0] t_hash;

    typedef enum logic [4:0] {
        S_IN   = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // sequencer to datapath
    typedef struct packed {
        logic       byte_en;
        logic [7:0] byte_val;
        logic       word_end;
        logic       load;
        logic       rnd_en;
        logic [5:0] rnd;
    } t_dp_ctl;

    // sequencer to chaining state
    typedef struct packed {
        logic fin;
        logic clr;
    } t_hash_ctl;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam t_hash HASH_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ hdl/sha256_round.sv @@
// sha256 round unit: byte packer, 16-word rolling schedule and working variables a..h
// depends on sha256_pkg
module sha256_round (
    input  logic                i_clk,
    input  sha256_pkg::t_dp_ctl i_dp,
    input  sha256_pkg::t_hash   i_hash,
    output sha256_pkg::t_hash   o_vars
);
    import sha256_pkg::*;

    logic [23:0] r_acc;
    logic [31:0] r_w [16];
    t_hash       r_v;

    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // window holds w[t..t+15]; each round also produces w[t+16]
    assign sched_new = sml_sig1(r_w[14]) + r_w[9] + sml_sig0(r_w[1]) + r_w[0];
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sig1(r_v[4]) + ch + K_TAB[i_dp.rnd] + r_w[0];
    assign t2  = big_sig0(r_v[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (i_dp.byte_en) begin
            r_acc <= {r_acc[15:0], i_dp.byte_val};
        end
        if (i_dp.byte_en && i_dp.word_end) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= {r_acc, i_dp.byte_val};
        end else if (i_dp.rnd_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= sched_new;
        end
        if (i_dp.load) begin
            r_v <= i_hash;
        end else if (i_dp.rnd_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_vars = r_v;

endmodule

@@ hdl/sha256_ctrl.sv @@
// sha256 sequencer: byte intake, padding, 64-round loop, digest readout
// depends on sha256_pkg and sha256_digest_macros.svh
`include "sha256_digest_macros.svh"
module sha256_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [2:0]            o_oidx,
    output sha256_pkg::t_dp_ctl   o_dp,
    output sha256_pkg::t_hash_ctl o_hc
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [60:0] r_count, n_count;
    logic [5:0]  r_pos,   n_pos;
    logic [63:0] r_len,   n_len;
    logic        r_pad,   n_pad;
    logic        r_mark,  n_mark;
    logic        r_inlen, n_inlen;
    logic [2:0]  r_lcnt,  n_lcnt;
    logic        r_lend,  n_lend;
    logic [5:0]  r_rnd,   n_rnd;
    logic [2:0]  r_oidx,  n_oidx;

    t_dp_ctl   dp;
    t_hash_ctl hc;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_len   = r_len;
        n_pad   = r_pad;
        n_mark  = r_mark;
        n_inlen = r_inlen;
        n_lcnt  = r_lcnt;
        n_lend  = r_lend;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        dp          = '0;
        dp.byte_val = i_s_tdata;
        dp.rnd      = r_rnd;
        dp.word_end = (r_pos[1:0] == 2'b11);
        hc          = '0;
        unique case (r_state)
            S_IN: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser) begin
                        dp.byte_en = 1'b1;
                        n_count    = r_count + 61'd1;
                        n_pos      = r_pos + 6'd1;
                    end
                    if (i_s_tlast) begin
                        n_len   = {r_count + 61'(i_s_tuser), 3'b000};
                        n_pad   = 1'b1;
                        n_mark  = 1'b0;
                        n_inlen = 1'b0;
                        n_lcnt  = '0;
                        n_lend  = 1'b0;
                    end
                    if (i_s_tuser && r_pos == LAST_POS) begin
                        dp.load = 1'b1;
                        n_rnd   = '0;
                        n_state = S_COMP;
                    end else if (i_s_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                dp.byte_en = 1'b1;
                n_pos      = r_pos + 6'd1;
                if (!r_mark) begin
                    dp.byte_val = PAD_MARK;
                    n_mark      = 1'b1;
                end else if (r_inlen || r_pos == LEN_POS) begin
                    // length goes out msb first
                    dp.byte_val = r_len[63:56];
                    n_len       = {r_len[55:0], 8'h00};
                    n_inlen     = 1'b1;
                    n_lcnt      = r_lcnt + 3'd1;
                    if (r_lcnt == LAST_IDX) begin
                        n_lend = 1'b1;
                    end
                end else begin
                    dp.byte_val = 8'h00;
                end
                if (r_pos == LAST_POS) begin
                    dp.load = 1'b1;
                    n_rnd   = '0;
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                dp.rnd_en = 1'b1;
                n_rnd     = r_rnd + 6'd1;
                if (r_rnd == LAST_RND) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                hc.fin = 1'b1;
                if (r_lend) begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IN;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LAST_IDX) begin
                        hc.clr  = 1'b1;
                        n_count = '0;
                        n_pad   = 1'b0;
                        n_lend  = 1'b0;
                        n_state = S_IN;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_count <= '0;
            r_pos   <= '0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_inlen <= 1'b0;
            r_lcnt  <= '0;
            r_lend  <= 1'b0;
            r_rnd   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_pad   <= n_pad;
            r_mark  <= n_mark;
            r_inlen <= n_inlen;
            r_lcnt  <= n_lcnt;
            r_lend  <= n_lend;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    assign o_s_tready = (r_state == S_IN);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_oidx     = r_oidx;
    assign o_dp       = dp;
    assign o_hc       = hc;

    `SHA_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IN), "not idle after reset")
    `SHA_ASSERT(a_load_comp, dp.load |=> (r_state == S_COMP && r_rnd == 6'd0),
        "block load did not start the round loop")
    `SHA_ASSERT(a_rnd_fin, (r_state == S_COMP && r_rnd == LAST_RND) |=> (r_state == S_FIN),
        "round loop did not finish after 64 rounds")
    `SHA_ASSERT(a_lend_pad, r_lend |-> r_pad, "length done outside padding")
    `SHA_ASSERT(a_out_done,
        (r_state == S_OUT && i_m_tready && r_oidx == LAST_IDX) |=>
        (r_state == S_IN && r_count == 61'd0 && r_pos == 6'd0),
        "state not cleared after last digest word")

endmodule

@@ hdl/sha256_digest.sv @@
// sha256 digest top level: chaining state and digest word output
// depends on sha256_pkg, sha256_ctrl and sha256_round
//
// SHA-256 over a byte stream, one message byte per input transaction (tuser
// marks a real byte, tlast ends the message). Bytes are taken one per cycle
// while a block fills; the 64th byte of a block starts the compression, which
// runs one round per cycle on a single round unit and ends with the chaining
// add, during both of which tready is low. After tlast the 0x80 mark, zero
// fill and the 64-bit bit length are fed in one byte per cycle, with a second
// compression when the tail does not fit; then the eight digest words are
// presented word 0 first, one per output transaction, and the block returns
// to the initial hash values.
module sha256_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] msg_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,   // last_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        o_m_tlast    // last_word
);
    import sha256_pkg::*;

    t_hash     r_hash;
    t_hash     vars;
    t_dp_ctl   dp;
    t_hash_ctl hc;
    logic [2:0] oidx;

    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_oidx     (oidx),
        .o_dp       (dp),
        .o_hc       (hc)
    );

    sha256_round u_round (
        .i_clk  (i_clk),
        .i_dp   (dp),
        .i_hash (r_hash),
        .o_vars (vars)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_IV;
        end else if (hc.clr) begin
            r_hash <= HASH_IV;
        end else if (hc.fin) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + vars[i];
            end
        end
    end

    assign o_m_tdata = {5'b00000, oidx, r_hash[oidx]};
    assign o_m_tlast = (oidx == LAST_IDX);

endmodule

@@ tb/sha256_digest_test.sv @@
// self-checking testbench of the sha256 digest block: byte stream in, digest words out
// depends on the sha256_digest rtl only; holds its own sha-256 predictor
module sha256_digest_test;

    typedef struct {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       last_of_message;
    } t_msg_item;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    localparam int TARGET_ITEMS = 320;
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_PCT     = 11;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_SLOT = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [7:0] msg_byte
    logic        i_s_tuser = 1'b0; // [0] byte_present
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // [31:0] digest_word, [34:32] word_index, zero fill
    logic        o_m_tlast;

    sha256_digest dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [31:0] chain_st [8];
    logic [7:0]  blk_buf [64];
    logic [60:0] byte_total;

    t_msg_item   msg_feed [$];
    t_digest_out digest_due [$];
    t_msg_item   on_bus;

    int mismatches = 0;
    int items_sent = 0;
    int bytes_sent = 0;
    int msgs_ended = 0;
    int words_checked = 0;
    int items_planned = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha256_compress();
        logic [31:0] w [16];
        logic [31:0] r [8];
        logic [31:0] nw, s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 0; i < 8; i++)
            r[i] = chain_st[i];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                nw = w[i];
            end else begin
                s0 = ror32(w[(i-15) & 15], 7) ^ ror32(w[(i-15) & 15], 18)
                     ^ (w[(i-15) & 15] >> 3);
                s1 = ror32(w[(i-2) & 15], 17) ^ ror32(w[(i-2) & 15], 19)
                     ^ (w[(i-2) & 15] >> 10);
                nw = w[i & 15] + s0 + w[(i-7) & 15] + s1;
                w[i & 15] = nw;
            end
            t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
                 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + nw;
            t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
                 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_st[i] = chain_st[i] + r[i];
    endfunction

    function automatic void sha256_restart();
        for (int i = 0; i < 8; i++)
            chain_st[i] = SHA_IV[i];
        byte_total = '0;
    endfunction

    // one accepted input transaction; an ending item queues all eight digest words
    function automatic void sha256_absorb(input t_msg_item it);
        logic [5:0]  pos;
        logic [63:0] bitlen;
        t_digest_out dw;
        if (it.byte_present) begin
            blk_buf[byte_total[5:0]] = it.msg_byte;
            byte_total = byte_total + 1'b1;
            if (byte_total[5:0] == 6'd0)
                sha256_compress();
        end
        if (it.last_of_message) begin
            pos = byte_total[5:0];
            bitlen = {byte_total, 3'b000};
            blk_buf[pos] = PAD_BYTE;
            for (int i = int'(pos) + 1; i < 64; i++)
                blk_buf[i] = '0;
            // length field no longer fits: flush this block and pad a fresh one
            if (pos >= LEN_SLOT) begin
                sha256_compress();
                for (int i = 0; i < 64; i++)
                    blk_buf[i] = '0;
            end
            for (int i = 0; i < 8; i++)
                blk_buf[LEN_SLOT + i] = bitlen[8*(7-i) +: 8];
            sha256_compress();
            for (int i = 0; i < 8; i++) begin
                dw.digest_word = chain_st[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (3'(i) == LAST_WORD_IDX);
                digest_due.push_back(dw);
            end
            sha256_restart();
        end
    endfunction

    function automatic void queue_item(input logic [7:0] b, input logic pres,
                                       input logic fin);
        t_msg_item it;
        it.msg_byte = b;
        it.byte_present = pres;
        it.last_of_message = fin;
        msg_feed.push_back(it);
        if (pres || fin)
            items_planned++;
    endfunction

    // random well-formed message; ignored filler items are sprinkled in
    function automatic void queue_message(input int len);
        logic end_on_byte;
        end_on_byte = ($urandom_range(0, 1) == 1) && (len > 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 5)
                queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            queue_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    // stimulus driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= 1'b0;
            i_s_tlast  <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                sha256_absorb(on_bus);
                items_sent++;
                if (on_bus.byte_present)
                    bytes_sent++;
                if (on_bus.last_of_message)
                    msgs_ended++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (msg_feed.size() != 0 && ((items_sent >= 120 && items_sent < 200)
                        || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_bus = msg_feed.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= on_bus.msg_byte;
                    i_s_tuser  <= on_bus.byte_present;
                    i_s_tlast  <= on_bus.last_of_message;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // digest word monitor
    always @(posedge i_clk) begin
        t_digest_out exp_w;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                words_checked++;
                if (digest_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected digest transaction, expected none, actual %h",
                             $time, o_m_tdata);
                end else begin
                    exp_w = digest_due.pop_front();
                    if (o_m_tdata[31:0] !== exp_w.digest_word) begin
                        mismatches++;
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.digest_word, o_m_tdata[31:0]);
                    end
                    if (o_m_tdata[34:32] !== exp_w.word_index) begin
                        mismatches++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, exp_w.word_index, o_m_tdata[34:32]);
                    end
                    if (o_m_tlast !== exp_w.last_word) begin
                        mismatches++;
                        $display("%0t: last_word expected %b actual %b",
                                 $time, exp_w.last_word, o_m_tlast);
                    end
                end
            end
            i_m_tready <= (words_checked >= 24 && words_checked < 64)
                          || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int edge_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        sha256_restart();
        for (int i = 0; i < 64; i++)
            blk_buf[i] = '0;

        // directed: filler, empty message, single bytes at the extremes,
        // byte carrying the end mark vs separate end item, filler inside a message
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'h12, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h34, 1'b1, 1'b1);
        queue_item(8'h80, 1'b1, 1'b0);
        queue_item(8'h7f, 1'b1, 1'b1);

        // random messages, lengths around the padding and block boundaries included
        while (items_planned < TARGET_ITEMS) begin
            if ($urandom_range(0, 99) < 35)
                queue_message(edge_lens[$urandom_range(0, 9)]);
            else
                queue_message($urandom_range(0, 20));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (msg_feed.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (digest_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d input transactions (%0d message bytes) in %0d messages",
                 items_sent, bytes_sent, msgs_ended);
        $display("checked %0d digest words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && digest_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d digest words outstanding", digest_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule
